// File: sv/thick_line_quad_corners_defines.svh
// ----------------------------------------------------------------------------
// Thick line quad corners: assertion macros
// Shared assertion wrappers; compiled out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef THICK_LINE_QUAD_CORNERS_DEFINES_SVH
`define THICK_LINE_QUAD_CORNERS_DEFINES_SVH
`ifndef SYNTH
// check while out of reset
`define TLQC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("thick_line_quad_corners: assertion failed");
// check at every edge, reset included
`define TLQC_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("thick_line_quad_corners: assertion failed");
`else
`define TLQC_ASSERT(lbl, prop)
`define TLQC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: sv/tlqc_pkg.sv
// ----------------------------------------------------------------------------
// Thick line quad corners package
// Widths and carried types of the segment expansion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package tlqc_pkg;
   localparam int IN_W    = 20;  // Q16.4 point coordinate
   localparam int D_W     = 21;  // direction component
   localparam int SQ_W    = 42;  // squared length
   localparam int V_W     = 62;  // radicand, squared length scaled by 2^20
   localparam int RT_W    = 31;  // root, length at 2^-14
   localparam int RM_W    = 32;  // root remainder
   localparam int THK_W   = 16;
   localparam int P_W     = 37;  // magnitude times thickness
   localparam int N_W     = 48;  // dividend
   localparam int Q_W     = 17;  // quotient
   localparam int DV_W    = 32;  // divisor, twice the length
   localparam int OUT_W   = 22;
   localparam int SQRT_STEPS = 31;

   typedef struct packed {
      logic signed [D_W-1:0] dx;
      logic signed [D_W-1:0] dy;
      logic                  zero;
   } side_type;
endpackage
`default_nettype wire

// File: sv/thick_line_quad_corners.sv
// ----------------------------------------------------------------------------
// Thick line quad corners
// Expands a line segment into the four corners of a quad of given half width.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req     | in  | start_x, start_y, end_x, end_y (Q16.4)
//  rsp     | out | corner0..3 x/y (Q18.4), zero_length flag in tuser
//  csr     | in  | APB register thickness at byte address 0
//
// One item per cycle sustained while rsp does not stall; stages are input,
// square, sum, 31 root steps, product, dividend, 17 divide steps, output register.
// The root and the two divisions are one bit per stage.
// Reset clears all valid bits and the thickness register.
// A stall on rsp freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
`include "thick_line_quad_corners_defines.svh"
module thick_line_quad_corners
   import tlqc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // start_x[19:0], start_y[39:20], end_x[59:40], end_y[79:60]
   input  wire logic [79:0]   req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
   // corner3_x, corner3_y, 22 bits each from bit 0 up
   output logic [175:0]       rsp_tdata,
   // zero_length
   output logic               rsp_tuser,
   input  wire logic          csr_psel,
   input  wire logic          csr_penable,
   input  wire logic          csr_pwrite,
   input  wire logic [2:0]    csr_paddr,
   input  wire logic [31:0]   csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // ---------------- configuration ----------------
   logic [THK_W-1:0] thk_ff;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thk_ff <= '0;
      end else if (csr_wr && csr_paddr[2] == 1'b0) begin
         thk_ff <= csr_pwdata[THK_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == 1'b0) begin
         csr_prdata = {{(32-THK_W){1'b0}}, thk_ff};
      end
   end

   // ---------------- flow control ----------------
   // whole pipeline advances unless the output holds an item not taken
   logic en;
   logic rsp_v_ff;
   assign en         = !rsp_v_ff || rsp_tready;
   assign req_tready = en;

   // ---------------- stage A: direction ----------------
   logic     vld_a_ff;
   side_type side_a_in, side_a_ff;
   logic signed [D_W-1:0] sx, sy, ex, ey;

   always_comb begin
      sx = D_W'(signed'(req_tdata[19:0]));
      sy = D_W'(signed'(req_tdata[39:20]));
      ex = D_W'(signed'(req_tdata[59:40]));
      ey = D_W'(signed'(req_tdata[79:60]));
      side_a_in.dx   = ex - sx;
      side_a_in.dy   = ey - sy;
      side_a_in.zero = (ex == sx) && (ey == sy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (en) begin
         vld_a_ff <= req_tvalid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         side_a_ff <= side_a_in;
      end
   end

   // ---------------- stage B: magnitudes and squares ----------------
   logic            vld_b_ff;
   side_type        side_b_ff;
   logic [D_W-1:0]  ax_in, ay_in, ax_b_ff, ay_b_ff;
   logic [SQ_W-1:0] sqx_b_ff, sqy_b_ff;

   assign ax_in = side_a_ff.dx[D_W-1] ? D_W'(-side_a_ff.dx) : D_W'(side_a_ff.dx);
   assign ay_in = side_a_ff.dy[D_W-1] ? D_W'(-side_a_ff.dy) : D_W'(side_a_ff.dy);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_b_ff <= 1'b0;
      end else if (en) begin
         vld_b_ff <= vld_a_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         side_b_ff <= side_a_ff;
         ax_b_ff   <= ax_in;
         ay_b_ff   <= ay_in;
         sqx_b_ff  <= SQ_W'(ax_in * ax_in);
         sqy_b_ff  <= SQ_W'(ay_in * ay_in);
      end
   end

   // ---------------- stage C: radicand ----------------
   logic            vld_c_ff;
   side_type        side_c_ff;
   logic [D_W-1:0]  ax_c_ff, ay_c_ff;
   logic [V_W-1:0]  rad_c_ff;
   logic [SQ_W-1:0] sum_sq;

   assign sum_sq = sqx_b_ff + sqy_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_c_ff <= 1'b0;
      end else if (en) begin
         vld_c_ff <= vld_b_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         side_c_ff <= side_b_ff;
         ax_c_ff   <= ax_b_ff;
         ay_c_ff   <= ay_b_ff;
         rad_c_ff  <= {sum_sq, {(V_W-SQ_W){1'b0}}};
      end
   end

   // ---------------- square root, one bit per stage ----------------
   logic            sq_v    [SQRT_STEPS+1];
   side_type        sq_side [SQRT_STEPS+1];
   logic [D_W-1:0]  sq_ax   [SQRT_STEPS+1];
   logic [D_W-1:0]  sq_ay   [SQRT_STEPS+1];
   logic [V_W-1:0]  sq_op   [SQRT_STEPS+1];
   logic [RM_W-1:0] sq_rem  [SQRT_STEPS+1];
   logic [RT_W-1:0] sq_root [SQRT_STEPS+1];

   assign sq_v[0]    = vld_c_ff;
   assign sq_side[0] = side_c_ff;
   assign sq_ax[0]   = ax_c_ff;
   assign sq_ay[0]   = ay_c_ff;
   assign sq_op[0]   = rad_c_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [RM_W+1:0] cur, trial, diff;
      logic            ge;
      logic            v_ff;
      side_type        side_ff;
      logic [D_W-1:0]  ax_ff, ay_ff;
      logic [V_W-1:0]  op_ff;
      logic [RM_W-1:0] rem_ff;
      logic [RT_W-1:0] root_ff;

      // bring down the next bit pair, try root*4+1
      assign cur   = {sq_rem[k], sq_op[k][V_W-1 -: 2]};
      assign trial = {1'b0, sq_root[k], 2'b01};
      assign ge    = cur >= trial;
      assign diff  = cur - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= sq_v[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff <= sq_side[k];
            ax_ff   <= sq_ax[k];
            ay_ff   <= sq_ay[k];
            op_ff   <= {sq_op[k][V_W-3:0], 2'b00};
            rem_ff  <= ge ? diff[RM_W-1:0] : cur[RM_W-1:0];
            root_ff <= {sq_root[k][RT_W-2:0], ge};
         end
      end

      assign sq_v[k+1]    = v_ff;
      assign sq_side[k+1] = side_ff;
      assign sq_ax[k+1]   = ax_ff;
      assign sq_ay[k+1]   = ay_ff;
      assign sq_op[k+1]   = op_ff;
      assign sq_rem[k+1]  = rem_ff;
      assign sq_root[k+1] = root_ff;
   end

   // ---------------- stage D: magnitude times thickness ----------------
   logic            vld_d_ff;
   side_type        side_d_ff;
   logic [P_W-1:0]  px_d_ff, py_d_ff;
   logic [RT_W-1:0] len_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_d_ff <= 1'b0;
      end else if (en) begin
         vld_d_ff <= sq_v[SQRT_STEPS];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         side_d_ff <= sq_side[SQRT_STEPS];
         px_d_ff   <= P_W'(sq_ay[SQRT_STEPS] * thk_ff);
         py_d_ff   <= P_W'(sq_ax[SQRT_STEPS] * thk_ff);
         len_d_ff  <= sq_root[SQRT_STEPS];
      end
   end

   // ---------------- stage E: dividend and divisor ----------------
   logic            vld_e_ff;
   side_type        side_e_ff;
   logic [N_W-1:0]  nx_e_ff, ny_e_ff;
   logic [DV_W-1:0] den_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_e_ff <= 1'b0;
      end else if (en) begin
         vld_e_ff <= vld_d_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         side_e_ff <= side_d_ff;
         // 2*m*T*1024 + L, rounding to nearest on division by 2L
         nx_e_ff   <= {px_d_ff, {(N_W-P_W){1'b0}}} + N_W'(len_d_ff);
         ny_e_ff   <= {py_d_ff, {(N_W-P_W){1'b0}}} + N_W'(len_d_ff);
         den_e_ff  <= {len_d_ff, 1'b0};
      end
   end

   // ---------------- two dividers, one quotient bit per stage ----------------
   logic            dv_v    [Q_W+1];
   side_type        dv_side [Q_W+1];
   logic [DV_W-1:0] dv_den  [Q_W+1];
   logic [DV_W-1:0] dv_rx   [Q_W+1];
   logic [DV_W-1:0] dv_ry   [Q_W+1];
   logic [Q_W-1:0]  dv_lx   [Q_W+1];
   logic [Q_W-1:0]  dv_ly   [Q_W+1];
   logic [Q_W-1:0]  dv_qx   [Q_W+1];
   logic [Q_W-1:0]  dv_qy   [Q_W+1];

   // quotient fits Q_W bits, so the upper dividend bits start below the divisor
   assign dv_v[0]    = vld_e_ff;
   assign dv_side[0] = side_e_ff;
   assign dv_den[0]  = den_e_ff;
   assign dv_rx[0]   = DV_W'(nx_e_ff[N_W-1:Q_W]);
   assign dv_ry[0]   = DV_W'(ny_e_ff[N_W-1:Q_W]);
   assign dv_lx[0]   = nx_e_ff[Q_W-1:0];
   assign dv_ly[0]   = ny_e_ff[Q_W-1:0];
   assign dv_qx[0]   = '0;
   assign dv_qy[0]   = '0;

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      logic [DV_W:0]   curx, cury, difx, dify, den_ext;
      logic            gex, gey;
      logic            v_ff;
      side_type        side_ff;
      logic [DV_W-1:0] den_ff, rx_ff, ry_ff;
      logic [Q_W-1:0]  lx_ff, ly_ff, qx_ff, qy_ff;

      assign den_ext = {1'b0, dv_den[k]};
      assign curx    = {dv_rx[k], dv_lx[k][Q_W-1]};
      assign cury    = {dv_ry[k], dv_ly[k][Q_W-1]};
      assign gex     = curx >= den_ext;
      assign gey     = cury >= den_ext;
      assign difx    = curx - den_ext;
      assign dify    = cury - den_ext;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= dv_v[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff <= dv_side[k];
            den_ff  <= dv_den[k];
            rx_ff   <= gex ? difx[DV_W-1:0] : curx[DV_W-1:0];
            ry_ff   <= gey ? dify[DV_W-1:0] : cury[DV_W-1:0];
            lx_ff   <= {dv_lx[k][Q_W-2:0], 1'b0};
            ly_ff   <= {dv_ly[k][Q_W-2:0], 1'b0};
            qx_ff   <= {dv_qx[k][Q_W-2:0], gex};
            qy_ff   <= {dv_qy[k][Q_W-2:0], gey};
         end
      end

      assign dv_v[k+1]    = v_ff;
      assign dv_side[k+1] = side_ff;
      assign dv_den[k+1]  = den_ff;
      assign dv_rx[k+1]   = rx_ff;
      assign dv_ry[k+1]   = ry_ff;
      assign dv_lx[k+1]   = lx_ff;
      assign dv_ly[k+1]   = ly_ff;
      assign dv_qx[k+1]   = qx_ff;
      assign dv_qy[k+1]   = qy_ff;
   end

   // ---------------- output stage: corners ----------------
   side_type                sd;
   logic signed [OUT_W-1:0] qxe, qye, ox, oy, dxe, dye;
   logic [175:0]            data_in, rsp_data_ff;
   logic                    rsp_zero_ff;

   always_comb begin
      sd  = dv_side[Q_W];
      qxe = OUT_W'(signed'({1'b0, dv_qx[Q_W]}));
      qye = OUT_W'(signed'({1'b0, dv_qy[Q_W]}));
      dxe = OUT_W'(sd.dx);
      dye = OUT_W'(sd.dy);
      // rotate left: offset is (-dy, dx) scaled; drop it on a zero segment
      if (sd.zero) begin
         ox = '0;
         oy = '0;
      end else begin
         ox = (sd.dy > 0) ? -qxe : qxe;
         oy = (sd.dx < 0) ? -qye : qye;
      end
      data_in = {-oy, -ox, dye - oy, dxe - ox, dye + oy, dxe + ox, oy, ox};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         rsp_v_ff <= dv_v[Q_W];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= data_in;
         rsp_zero_ff <= sd.zero;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_zero_ff;

   // ---------------- checks ----------------
   `TLQC_ASSERT_ALWAYS(a_reset_clears_out, $past(reset) |-> !rsp_tvalid)
   `TLQC_ASSERT(a_zero_gives_zero, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
   `TLQC_ASSERT(a_stall_freezes_pipe, !en |=> ($stable(vld_e_ff) && $stable(vld_a_ff)))

endmodule
`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// Thick line quad corners testbench
// Drives segments through the stream input with random gaps and stalls,
// predicts the four quad corners per segment and checks each output item.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   import tlqc_pkg::*;

   typedef struct packed {
      logic signed [OUT_W-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
      logic                    zero;
   } quad_type;

   localparam int LATENCY = 54;
   localparam int MAX_CYCLES = 1000000;
   localparam logic [2:0] THICKNESS_ADDR = 3'd0;
   localparam logic [2:0] UNUSED_ADDR = 3'd4;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   wire           req_tready;
   logic [79:0]   req_tdata = '0;
   wire           rsp_tvalid;
   logic          rsp_tready = 1'b0;
   wire  [175:0]  rsp_tdata;  // corner0_x .. corner3_y, 22 bits each from bit 0
   wire           rsp_tuser;  // zero_length
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [2:0]    csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   wire  [31:0]   csr_prdata;
   wire           csr_pready;

   // thickness as the predictor sees it
   logic [THK_W-1:0] thick_now = '0;
   quad_type         quad_queue[$];
   int               fail_count = 0;
   int               seg_count = 0;
   int               quad_count = 0;
   int               zero_count = 0;
   longint           cycle_count = 0;
   bit               allow_idle = 1'b1;

   thick_line_quad_corners dut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // corners of the quad for one segment at the current thickness
   function automatic quad_type quad_of(input logic [79:0] seg);
      longint dx, dy, ax, ay, ox, oy, qx, qy;
      logic [63:0] len;
      quad_type q;
      dx = longint'($signed(seg[59:40])) - longint'($signed(seg[19:0]));
      dy = longint'($signed(seg[79:60])) - longint'($signed(seg[39:20]));
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      ox = 0;
      oy = 0;
      q.zero = (dx == 0 && dy == 0);
      if (!q.zero) begin
         len = root_floor(64'(ax * ax + ay * ay) << 20);
         qx = longint'((2 * 64'(ay) * thick_now * 1024 + len) / (2 * len));
         qy = longint'((2 * 64'(ax) * thick_now * 1024 + len) / (2 * len));
         ox = dy > 0 ? -qx : qx;
         oy = dx < 0 ? -qy : qy;
      end
      q.c0x = ox[OUT_W-1:0];  q.c0y = oy[OUT_W-1:0];
      q.c1x = OUT_W'(dx + ox); q.c1y = OUT_W'(dy + oy);
      q.c2x = OUT_W'(dx - ox); q.c2y = OUT_W'(dy - oy);
      q.c3x = OUT_W'(-ox);    q.c3y = OUT_W'(-oy);
      return q;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch item %0d %s: got %0d want %0d", quad_count, what, got, want);
      fail_count++;
   endtask

   // output side: random stalls, compare each item with the oldest prediction
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (quad_queue.size() == 0) begin
               report("unexpected item", 0, 0);
            end else begin
               quad_type w, g;
               w = quad_queue.pop_front();
               g = {rsp_tdata[21:0], rsp_tdata[43:22], rsp_tdata[65:44],
                    rsp_tdata[87:66], rsp_tdata[109:88], rsp_tdata[131:110],
                    rsp_tdata[153:132], rsp_tdata[175:154], rsp_tuser};
               if (g.c0x !== w.c0x) report("corner0_x", g.c0x, w.c0x);
               if (g.c0y !== w.c0y) report("corner0_y", g.c0y, w.c0y);
               if (g.c1x !== w.c1x) report("corner1_x", g.c1x, w.c1x);
               if (g.c1y !== w.c1y) report("corner1_y", g.c1y, w.c1y);
               if (g.c2x !== w.c2x) report("corner2_x", g.c2x, w.c2x);
               if (g.c2y !== w.c2y) report("corner2_y", g.c2y, w.c2y);
               if (g.c3x !== w.c3x) report("corner3_x", g.c3x, w.c3x);
               if (g.c3y !== w.c3y) report("corner3_y", g.c3y, w.c3y);
               if (g.zero !== w.zero) report("zero_length", g.zero, w.zero);
               if (w.zero) zero_count++;
            end
            quad_count++;
         end
         // occasionally stall in bursts, hold ready otherwise
         if (allow_idle && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 19);
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // send one segment; predict at acceptance
   task automatic send_segment(input logic [79:0] seg);
      if (allow_idle && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= seg;
      do @(posedge clock); while (!req_tready);
      quad_queue.push_back(quad_of(seg));
      seg_count++;
   endtask

   task automatic send_points(input int sx, sy, ex, ey);
      send_segment({ey[19:0], ex[19:0], sy[19:0], sx[19:0]});
   endtask

   // drop valid and wait out the pipeline before touching the register
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (quad_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= value;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == THICKNESS_ADDR) thick_now = value[THK_W-1:0];
   endtask

   function automatic logic [79:0] random_segment;
      logic [79:0] seg;
      int span;
      seg = 80'({$urandom, $urandom, $urandom});
      // half the segments short, endpoints near each other; the rest random, some zero-length
      case ($urandom_range(0, 3))
         0: ;
         1: begin
            span = $urandom_range(0, 64) - 32;
            seg[59:40] = seg[19:0] + span[19:0];
            span = $urandom_range(0, 64) - 32;
            seg[79:60] = seg[39:20] + span[19:0];
         end
         2: begin
            seg[59:40] = seg[19:0] + 20'($urandom_range(0, 4000)) - 20'd2000;
            seg[79:60] = seg[39:20] + 20'($urandom_range(0, 4000)) - 20'd2000;
         end
         default: if ($urandom_range(0, 5) == 0) seg[79:40] = seg[39:0];
      endcase
      return seg;
   endfunction

   task automatic test_directed_extremes;
      csr_write(THICKNESS_ADDR, 32'd16);
      send_points(0, 0, 0, 0);                               // zero-length segment
      send_points(-524288, -524288, -524288, -524288);       // zero-length at corner
      send_points(-524288, -524288, 524287, 524287);         // longest diagonal
      send_points(524287, 524287, -524288, -524288);
      send_points(-524288, 524287, 524287, -524288);
      send_points(0, 0, 16, 0);                              // axis aligned, all signs
      send_points(0, 0, -16, 0);
      send_points(0, 0, 0, 16);
      send_points(0, 0, 0, -16);
      send_points(5, 7, 6, 7);                               // unit step
      send_points(0, 0, 3, 4);
      send_points(0, 0, 1, 1);
      drain();
      csr_write(THICKNESS_ADDR, 32'hFFFF);                   // maximal thickness
      send_points(0, 0, 1, 0);
      send_points(0, 0, -1, -1);
      send_points(-524288, 0, 524287, 0);
      send_points(0, 524287, 0, -524288);
      send_points(100, -200, -300, 400);
      drain();
      csr_write(THICKNESS_ADDR, 32'd0);                      // zero thickness
      send_points(1, 2, 300, -40);
      send_points(-524288, -524288, 524287, 524287);
      send_points(9, 9, 9, 9);
      drain();
      csr_write(UNUSED_ADDR, 32'hFFFF);                      // ignored register
      send_points(0, 0, 10, 10);
      drain();
   endtask

   task automatic test_random_thickness;
      logic [31:0] thick_list[5] = '{32'd1, 32'd40, 32'd1000, 32'hFFFF, 32'hABCD0123};
      foreach (thick_list[i]) begin
         csr_write(THICKNESS_ADDR, thick_list[i]);
         repeat (150) send_segment(random_segment());
         drain();  // hold until every corner set is back
      end
   endtask

   task automatic test_back_to_back;
      allow_idle = 1'b0;
      csr_write(THICKNESS_ADDR, 32'd24);
      repeat (280) send_segment(random_segment());
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_random_thickness();
      test_back_to_back();
      $display("sent %0d segments, checked %0d corner sets (%0d zero-length)",
               seg_count, quad_count, zero_count);
      $display("thickness swept from zero to full scale, with and without stalls");
      if (fail_count == 0 && quad_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
